FILE: rtl/ptsp_pkg.sv
`default_nettype none

package ptsp_pkg;

    localparam int unsigned REQ_W    = 3;
    localparam int unsigned SLOT_W   = 3;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned FIRE_W   = 8;
    localparam int unsigned BITCNT_W = $clog2(COUNT_W);

    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK    = 3'd0,
        REQ_CREATE  = 3'd1,
        REQ_DESTROY = 3'd2,
        REQ_START   = 3'd3,
        REQ_STOP    = 3'd4
    } t_req;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_DIV   = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/periodic_timer_slot_pool_core.sv
`default_nettype none

// Pool of NUM_SLOTS periodic timer slots driven by one request per stream item,
// each request answered by exactly one result. Create, destroy, start, stop and
// unknown requests go from acceptance to the emit state and then to the output
// register. A tick visits every slot in turn: a single bit-serial remainder
// unit is shared by all slots, fetching a slot's period in the fetch state and
// then shifting the tick count through it one bit per cycle. A request is
// taken only while no other is in work; a finished result waits in the output
// register. A period of zero never fires; slots at index 8 and above take part
// in create and tick but cannot be addressed and do not show in the fire mask.
module periodic_timer_slot_pool_core #(
    parameter int unsigned NUM_SLOTS = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // req_type[2:0], slot[5:3], period[21:6], zero[23:22]
    input  wire logic [ptsp_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // alloc_ok[0], alloc_slot[3:1], fire_mask[11:4], tick_count[27:12], zero[31:28]
    output logic [ptsp_pkg::M_TDATA_W-1:0]       m_axis_tdata
);
    import ptsp_pkg::*;

    localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    t_state                r_state;
    logic [NUM_SLOTS-1:0]  r_used;
    logic [NUM_SLOTS-1:0]  r_run;
    logic [PERIOD_W-1:0]   r_period [NUM_SLOTS];
    logic [COUNT_W-1:0]    r_count;
    logic [SW-1:0]         r_idx;
    logic [BITCNT_W-1:0]   r_bitcnt;
    logic [PERIOD_W-1:0]   r_div_p;
    logic                  r_act;
    logic [COUNT_W-1:0]    r_dvd;
    logic [PERIOD_W-1:0]   r_rem;
    logic [FIRE_W-1:0]     r_fire;
    logic                  r_ok;
    logic [SLOT_W-1:0]     r_gslot;
    logic                  r_out_valid;
    logic [M_TDATA_W-1:0]  r_out_data;

    logic                  n_accept;
    logic [REQ_W-1:0]      n_req;
    logic [SLOT_W-1:0]     n_slot;
    logic [PERIOD_W-1:0]   n_period;
    logic [7:0]            n_slot_ext;
    logic [SW-1:0]         n_slot_idx;
    logic                  n_slot_ok;
    logic                  n_free_found;
    logic [SW-1:0]         n_free_idx;
    logic [PERIOD_W:0]     n_rem_sh;
    logic [PERIOD_W:0]     n_rem_sub;
    logic [PERIOD_W-1:0]   n_rem;
    logic                  n_hit;
    logic                  n_last_bit;
    logic                  n_last_slot;
    logic                  n_emit;

    assign s_axis_tready = (r_state == S_IDLE);
    assign n_accept      = s_axis_tvalid && s_axis_tready;
    assign n_req         = s_axis_tdata[2:0];
    assign n_slot        = s_axis_tdata[5:3];
    assign n_period      = s_axis_tdata[21:6];
    assign n_slot_ext    = {5'd0, n_slot};
    assign n_slot_idx    = n_slot_ext[SW-1:0];
    assign n_slot_ok     = (32'(n_slot) < NUM_SLOTS);

    always_comb begin
        n_free_found = 1'b0;
        n_free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                n_free_found = 1'b1;
                n_free_idx   = SW'(i);
            end
        end
    end

    assign n_rem_sh    = {r_rem, r_dvd[COUNT_W-1]};
    assign n_rem_sub   = n_rem_sh - {1'b0, r_div_p};
    assign n_rem       = (n_rem_sh >= {1'b0, r_div_p}) ? n_rem_sub[PERIOD_W-1:0]
                                                       : n_rem_sh[PERIOD_W-1:0];
    assign n_last_bit  = (r_bitcnt == BITCNT_W'(COUNT_W - 1));
    assign n_last_slot = (r_idx == SW'(NUM_SLOTS - 1));
    assign n_hit       = r_act && (r_div_p != '0) && (n_rem == '0);
    assign n_emit      = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_run       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_EMIT) && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_state <= (n_req == REQ_TICK) ? S_FETCH : S_EMIT;
                        case (n_req)
                            REQ_TICK: begin
                                r_count <= r_count + 1'b1;
                            end
                            REQ_CREATE: begin
                                if (n_free_found) begin
                                    r_used[n_free_idx] <= 1'b1;
                                    r_run[n_free_idx]  <= 1'b0;
                                end
                            end
                            REQ_DESTROY: begin
                                if (n_slot_ok) begin
                                    r_used[n_slot_idx] <= 1'b0;
                                end
                            end
                            REQ_START: begin
                                if (n_slot_ok) begin
                                    r_run[n_slot_idx] <= 1'b1;
                                end
                            end
                            REQ_STOP: begin
                                if (n_slot_ok) begin
                                    r_run[n_slot_idx] <= 1'b0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_FETCH: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (n_last_bit) begin
                        r_state <= n_last_slot ? S_EMIT : S_FETCH;
                    end
                end
                S_EMIT: begin
                    if (n_emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_fire <= '0;
                r_idx  <= '0;
                if (n_accept && (n_req == REQ_CREATE) && n_free_found) begin
                    r_period[n_free_idx] <= n_period;
                    r_ok                 <= 1'b1;
                    r_gslot              <= SLOT_W'({3'd0, n_free_idx});
                end else begin
                    r_ok    <= 1'b0;
                    r_gslot <= '0;
                end
            end
            S_FETCH: begin
                r_div_p  <= r_period[r_idx];
                r_act    <= r_used[r_idx] && r_run[r_idx];
                r_dvd    <= r_count;
                r_rem    <= '0;
                r_bitcnt <= '0;
            end
            S_DIV: begin
                r_rem    <= n_rem;
                r_dvd    <= {r_dvd[COUNT_W-2:0], 1'b0};
                r_bitcnt <= r_bitcnt + 1'b1;
                if (n_last_bit) begin
                    r_fire <= r_fire | (FIRE_W'(n_hit) << r_idx);
                    r_idx  <= r_idx + 1'b1;
                end
            end
            S_EMIT: begin
                if (n_emit) begin
                    r_out_data <= {4'd0, r_count, r_fire, r_gslot, r_ok};
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
